@@ sv/riffdf_pkg.sv @@
// ----------------------------------------------------------------------------
// riffdf_pkg
// Shared types and constants for the RIFF chunk deframer.
// ----------------------------------------------------------------------------
package riffdf_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned OFF_BITS  = WORD_BITS + 1;

  localparam logic [WORD_BITS-1:0] SIG_RIFF = 32'h4646_4952;
  localparam logic [WORD_BITS-1:0] SIG_RIFX = 32'h5846_4952;
  localparam logic [WORD_BITS-1:0] SIG_FFIR = 32'h5249_4646;

  // "WAVE" as assembled in file byte order
  localparam logic [WORD_BITS-1:0] FORM_TYPE_RESET = 32'h4556_4157;

  localparam logic [OFF_BITS-1:0] OFFSET_MAX = {OFF_BITS{1'b1}};
  // declared length excludes the signature and length fields
  localparam logic [OFF_BITS:0] HDR_BYTES = 8;

  typedef enum logic [3:0] {
    PH_SIG   = 4'd0,
    PH_LEN   = 4'd1,
    PH_FORM  = 4'd2,
    PH_CID   = 4'd3,
    PH_CSIZE = 4'd4,
    PH_PAY   = 4'd5,
    PH_PAD   = 4'd6,
    PH_TRAIL = 4'd7,
    PH_REJ   = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SIG   = 2'd1,
    ST_FORM_MISM = 2'd2,
    ST_TRUNC     = 2'd3
  } status_t;

  typedef struct packed {
    phase_t                phase;
    logic [7:0]            payload_byte;
    logic [WORD_BITS-1:0]  chunk_id;
    logic [WORD_BITS-1:0]  chunk_size;
    logic                  chunk_begin;
    logic                  chunk_end;
    logic                  big_endian;
    status_t               status;
    logic                  done_res;
  } res_t;

endpackage

@@ sv/riff_chunk_deframer.sv @@
// ----------------------------------------------------------------------------
// riff_chunk_deframer
// Byte-serial RIFF/RIFX container parser: checks the header and splits the
// body into chunk id, size, payload and pad bytes, one result per byte.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  in      | input     | in_valid/in_stall  | in_byte, in_last_byte
//  out     | output    | out_valid/out_stall| out_phase ... out_done_res
//  cfg     | input     | cfg_wr_en          | cfg_wr_data (form type)
//
//  One byte per cycle while in_stall is low; each result appears in the cycle after its byte is accepted.
//  The parse state updates in the accept cycle; the result sits in an output
//  register, so a new byte is taken while the previous result drains.
//  in_stall is high only while a result is held and out_stall is high.
//  Synchronous active-low reset clears parse state and the output valid.
//
module riff_chunk_deframer (
  input  logic                                clk,
  input  logic                                rst_n,
  // input bytes
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_byte,
  input  logic                                in_last_byte,
  // results
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [3:0]                          out_phase,
  output logic [7:0]                          out_payload_byte,
  output logic [riffdf_pkg::WORD_BITS-1:0]    out_chunk_id,
  output logic [riffdf_pkg::WORD_BITS-1:0]    out_chunk_size,
  output logic                                out_chunk_begin,
  output logic                                out_chunk_end,
  output logic                                out_big_endian,
  output logic [1:0]                          out_status,
  output logic                                out_done_res,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [riffdf_pkg::WORD_BITS-1:0]    cfg_wr_data
);

  localparam int unsigned WB = riffdf_pkg::WORD_BITS;
  localparam int unsigned OB = riffdf_pkg::OFF_BITS;

  // state
  riffdf_pkg::phase_t  ph_r,  ph_s;
  riffdf_pkg::status_t rej_r, rej_s;
  logic [1:0]    cnt_r,   cnt_s;
  logic [WB-1:0] wa_r,    wa_s;
  logic [OB-1:0] off_r,   off_s;
  logic [WB-1:0] len_r,   len_s;
  logic [WB-1:0] rem_r,   rem_s;
  logic [WB-1:0] cid_r,   cid_s;
  logic [WB-1:0] csize_r, csize_s;
  logic          be_r,    be_s;
  logic [WB-1:0] form_r;

  riffdf_pkg::res_t res_r, res_nxt;
  logic             out_valid_r;
  logic             accept;

  // helpers
  logic          le;
  logic [WB-1:0] asm_w;
  logic          in_field;
  logic          fld_done;
  logic          sig_le, sig_be, sig_ok, form_ok;
  logic [WB-1:0] rem_dec;
  logic          rem_zero;
  logic          at_end;
  logic          odd;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign le       = (ph_r == riffdf_pkg::PH_SIG) || !be_r;
  assign asm_w    = le ? {in_byte, wa_r[WB-1:8]} : {wa_r[WB-9:0], in_byte};
  assign in_field = (ph_r == riffdf_pkg::PH_SIG) || (ph_r == riffdf_pkg::PH_LEN) ||
                    (ph_r == riffdf_pkg::PH_FORM) || (ph_r == riffdf_pkg::PH_CID) ||
                    (ph_r == riffdf_pkg::PH_CSIZE);
  assign fld_done = in_field && (cnt_r == 2'd3);
  assign sig_le   = (asm_w == riffdf_pkg::SIG_RIFF);
  assign sig_be   = (asm_w == riffdf_pkg::SIG_RIFX) || (asm_w == riffdf_pkg::SIG_FFIR);
  assign sig_ok   = sig_le || sig_be;
  assign form_ok  = (asm_w == form_r);
  assign rem_dec  = rem_r - WB'(1);
  assign rem_zero = (rem_dec == '0);

  // offset counts every byte up to and including the pad; saturates
  always_comb begin
    off_s = off_r;
    if ((ph_r <= riffdf_pkg::PH_PAD) && (off_r != riffdf_pkg::OFFSET_MAX))
      off_s = off_r + OB'(1);
  end

  assign at_end = {1'b0, off_s} >= ({2'b00, len_r} + riffdf_pkg::HDR_BYTES);
  assign odd    = off_s[0];

  // next state
  always_comb begin
    ph_s    = ph_r;
    cnt_s   = cnt_r;
    wa_s    = wa_r;
    len_s   = len_r;
    rem_s   = rem_r;
    cid_s   = cid_r;
    csize_s = csize_r;
    be_s    = be_r;
    rej_s   = rej_r;
    unique case (ph_r)
      riffdf_pkg::PH_SIG, riffdf_pkg::PH_LEN, riffdf_pkg::PH_FORM,
      riffdf_pkg::PH_CID, riffdf_pkg::PH_CSIZE: begin
        if (cnt_r == 2'd3) begin
          cnt_s = 2'd0;
          wa_s  = '0;
          unique case (ph_r)
            riffdf_pkg::PH_SIG: begin
              if (sig_ok) begin
                be_s = sig_be;
                ph_s = riffdf_pkg::PH_LEN;
              end else begin
                rej_s = riffdf_pkg::ST_BAD_SIG;
                ph_s  = riffdf_pkg::PH_REJ;
              end
            end
            riffdf_pkg::PH_LEN: begin
              len_s = asm_w;
              ph_s  = riffdf_pkg::PH_FORM;
            end
            riffdf_pkg::PH_FORM: begin
              if (!form_ok) begin
                rej_s = riffdf_pkg::ST_FORM_MISM;
                ph_s  = riffdf_pkg::PH_REJ;
              end else begin
                ph_s = at_end ? riffdf_pkg::PH_TRAIL : riffdf_pkg::PH_CID;
              end
            end
            riffdf_pkg::PH_CID: begin
              cid_s = asm_w;
              ph_s  = riffdf_pkg::PH_CSIZE;
            end
            default: begin
              csize_s = asm_w;
              rem_s   = asm_w;
              if (asm_w != '0)
                ph_s = riffdf_pkg::PH_PAY;
              else if (odd)
                ph_s = riffdf_pkg::PH_PAD;
              else
                ph_s = at_end ? riffdf_pkg::PH_TRAIL : riffdf_pkg::PH_CID;
            end
          endcase
        end else begin
          cnt_s = cnt_r + 2'd1;
          wa_s  = asm_w;
        end
      end
      riffdf_pkg::PH_PAY: begin
        rem_s = rem_dec;
        if (rem_zero) begin
          if (odd)
            ph_s = riffdf_pkg::PH_PAD;
          else
            ph_s = at_end ? riffdf_pkg::PH_TRAIL : riffdf_pkg::PH_CID;
        end
      end
      riffdf_pkg::PH_PAD: begin
        ph_s = at_end ? riffdf_pkg::PH_TRAIL : riffdf_pkg::PH_CID;
      end
      default: ;
    endcase
  end

  // result fields
  always_comb begin
    res_nxt              = '0;
    res_nxt.phase        = ph_r;
    res_nxt.chunk_id     = cid_s;
    res_nxt.chunk_size   = csize_s;
    res_nxt.big_endian   = be_s;
    res_nxt.status       = riffdf_pkg::ST_OK;
    res_nxt.done_res     = 1'b0;
    if (ph_r == riffdf_pkg::PH_PAY)
      res_nxt.payload_byte = in_byte;

    priority if (ph_r == riffdf_pkg::PH_REJ) begin
      res_nxt.status = rej_r;
    end else if (fld_done && (ph_r == riffdf_pkg::PH_SIG) && !sig_ok) begin
      res_nxt.phase  = riffdf_pkg::PH_REJ;
      res_nxt.status = riffdf_pkg::ST_BAD_SIG;
    end else if (fld_done && (ph_r == riffdf_pkg::PH_FORM) && !form_ok) begin
      res_nxt.phase  = riffdf_pkg::PH_REJ;
      res_nxt.status = riffdf_pkg::ST_FORM_MISM;
    end else begin
    end

    res_nxt.chunk_begin = fld_done && (ph_r == riffdf_pkg::PH_CSIZE);
    res_nxt.chunk_end   = (res_nxt.chunk_begin && (asm_w == '0)) ||
                          ((ph_r == riffdf_pkg::PH_PAY) && rem_zero);

    // chunk or file boundary reached at the declared end
    if (((fld_done && (ph_r == riffdf_pkg::PH_FORM) && form_ok) ||
         (res_nxt.chunk_end && !odd) ||
         (ph_r == riffdf_pkg::PH_PAD)) && at_end)
      res_nxt.done_res = 1'b1;
    if (ph_r == riffdf_pkg::PH_TRAIL)
      res_nxt.done_res = 1'b1;

    if (in_last_byte) begin
      res_nxt.done_res = 1'b1;
      if (ph_s <= riffdf_pkg::PH_FORM)
        res_nxt.status = riffdf_pkg::ST_BAD_SIG;
      else if ((ph_s == riffdf_pkg::PH_CSIZE) || (ph_s == riffdf_pkg::PH_PAY) ||
               ((ph_s == riffdf_pkg::PH_CID) && (cnt_s != 2'd0)))
        res_nxt.status = riffdf_pkg::ST_TRUNC;
    end
  end

  // parse state; a final byte returns everything but the form type to reset
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_last_byte)) begin
      ph_r    <= riffdf_pkg::PH_SIG;
      cnt_r   <= '0;
      wa_r    <= '0;
      off_r   <= '0;
      len_r   <= '0;
      rem_r   <= '0;
      cid_r   <= '0;
      csize_r <= '0;
      be_r    <= 1'b0;
      rej_r   <= riffdf_pkg::ST_OK;
    end else if (accept) begin
      ph_r    <= ph_s;
      cnt_r   <= cnt_s;
      wa_r    <= wa_s;
      off_r   <= off_s;
      len_r   <= len_s;
      rem_r   <= rem_s;
      cid_r   <= cid_s;
      csize_r <= csize_s;
      be_r    <= be_s;
      rej_r   <= rej_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      form_r <= riffdf_pkg::FORM_TYPE_RESET;
    else if (cfg_wr_en)
      form_r <= cfg_wr_data;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (accept)
      out_valid_r <= 1'b1;
    else if (!out_stall)
      out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (accept)
      res_r <= res_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_phase        = res_r.phase;
  assign out_payload_byte = res_r.payload_byte;
  assign out_chunk_id     = res_r.chunk_id;
  assign out_chunk_size   = res_r.chunk_size;
  assign out_chunk_begin  = res_r.chunk_begin;
  assign out_chunk_end    = res_r.chunk_end;
  assign out_big_endian   = res_r.big_endian;
  assign out_status       = res_r.status;
  assign out_done_res     = res_r.done_res;

endmodule
